// ===== rtl/core/heat_index_calculator_top_macros.svh =====
// Assertion macros for the heat index calculator.
`ifndef HEAT_INDEX_CALCULATOR_TOP_MACROS_SVH
`define HEAT_INDEX_CALCULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HIC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heat index check failed");
`define HIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heat index check failed");
`else
`define HIC_ASSERT_NOW(label, ante, cons)
`define HIC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/hic_pkg.sv =====
package hic_pkg;

   typedef struct packed {
      logic signed [11:0] temp_tenths_f;
      logic [9:0]         humidity_tenths;
   } hic_req_type;

   typedef struct packed {
      logic signed [14:0] heat_index_tenths_f;
      logic               saturated;
      logic [1:0]         formula_used;
   } hic_rsp_type;

   typedef enum logic [1:0] {
      FORMULA_PLAIN    = 2'd0,
      FORMULA_DRY      = 2'd1,
      FORMULA_HUMID    = 2'd2,
      FORMULA_FALLBACK = 2'd3
   } formula_type;

   localparam int NUM_STAGES = 9;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] valid;
   } stage_ctrl_type;

   localparam int RW = 62;
   localparam int NW = 60;
   localparam int QW = 33;
   localparam int AW = 19;
   localparam int FW = 14;

   typedef struct packed {
      formula_type            formula;
      logic signed [AW-1:0]   adj;
      logic signed [FW-1:0]   fb_tenths;
   } adj_type;

   localparam logic signed [RW-1:0] REG_C0       = -62'sd42379000000000;
   localparam logic signed [RW-1:0] REG_C_T      = 62'sd204901523000;
   localparam logic signed [RW-1:0] REG_C_H      = 62'sd1014333127000;
   localparam logic signed [RW-1:0] REG_C_TH     = 62'sd2247554100;
   localparam logic signed [RW-1:0] REG_C_TSQ    = 62'sd68378300;
   localparam logic signed [RW-1:0] REG_C_HSQ    = 62'sd548171700;
   localparam logic signed [RW-1:0] REG_C_TSQH   = 62'sd1228740;
   localparam logic signed [RW-1:0] REG_C_THSQ   = 62'sd852820;
   localparam logic signed [RW-1:0] REG_C_TSQHSQ = 62'sd199;
   localparam logic signed [RW-1:0] REG_N_OFFSET = 62'sd524288000244140625;

   localparam logic [28:0] DIV_D     = 29'd488281250;
   localparam logic [33:0] DIV_RECIP = 34'd9444732965;
   localparam logic signed [QW-1:0] Q_BIAS = 33'sd1073741824;

   localparam logic [26:0] HUM_RECIP = 27'd109951163;
   localparam logic [20:0] FB_RECIP  = 21'd1073742;
   localparam logic [20:0] DRY_RECIP = 21'd1677722;

   localparam logic signed [33:0] LOW_LIMIT = 34'sd5242880;
   localparam logic signed [21:0] HI_MAX    = 22'sd9999;

   typedef logic [16:0] root_lut_type [256];

   function automatic root_lut_type build_root_lut();
      root_lut_type lut;
      logic [63:0]  v;
      logic [63:0]  res;
      logic [63:0]  step;
      for (int i = 0; i < 256; i++) begin
         if (i < 170) begin
            v    = (64'(170 - i) << 32) / 64'd170;
            res  = '0;
            step = 64'h4000_0000_0000_0000;
            for (int k = 0; k < 32; k++) begin
               if (v >= res + step) begin
                  v   = v - (res + step);
                  res = (res >> 1) + step;
               end else begin
                  res = res >> 1;
               end
               step = step >> 2;
            end
            lut[i] = res[16:0];
         end else begin
            lut[i] = '0;
         end
      end
      return lut;
   endfunction

   localparam root_lut_type ROOT_LUT = build_root_lut();

endpackage

// ===== rtl/core/heat_index_calculator_top.sv =====
// The stall chain runs through all 9 stages, from req_ready to rsp_valid.
// Throughput: one transaction per cycle unless stalled by rsp_ready.
// The depth is set by the constant reciprocal division of the regression sum.
// Reset clears the stage valid bits only; datapath registers are not reset.
`include "heat_index_calculator_top_macros.svh"
module heat_index_calculator_top import hic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hic_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hic_rsp_type rsp_data
);

   stage_ctrl_type       ctrl;
   logic signed [QW-1:0] q_base;
   adj_type              adj;

   logic signed [33:0]   q8_ff, q8_in;
   formula_type          f8_ff;
   logic signed [FW-1:0] fb8_ff;

   logic                 low_w;
   logic signed [37:0]   scaled_w;
   logic signed [21:0]   tenths_w;
   hic_rsp_type          rsp_ff, rsp_in;

   hic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   hic_regress u_regress (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_data (req_data),
      .q_base   (q_base)
   );

   hic_adjust u_adjust (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_data (req_data),
      .adj_out  (adj)
   );

   always_comb begin
      q8_in    = 34'(q_base) + 34'(adj.adj);
      low_w    = q8_ff < LOW_LIMIT;
      scaled_w = 38'(q8_ff) * 38'sd10 + 38'sd32768;
      tenths_w = low_w ? 22'(fb8_ff) : scaled_w[37:16];
      rsp_in.formula_used = low_w ? FORMULA_FALLBACK : f8_ff;
      if (tenths_w > HI_MAX) begin
         rsp_in.heat_index_tenths_f = HI_MAX[14:0];
         rsp_in.saturated           = 1'b1;
      end else if (tenths_w < -HI_MAX) begin
         rsp_in.heat_index_tenths_f = 15'(-HI_MAX);
         rsp_in.saturated           = 1'b1;
      end else begin
         rsp_in.heat_index_tenths_f = tenths_w[14:0];
         rsp_in.saturated           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[7]) begin
         q8_ff  <= q8_in;
         f8_ff  <= adj.formula;
         fb8_ff <= adj.fb_tenths;
      end
      if (ctrl.en[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   `HIC_ASSERT_NOW(a_stall_full, !req_ready, (&ctrl.valid) && !rsp_ready)
   `HIC_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, ctrl.valid[0])
   `HIC_ASSERT_NOW(a_sat_clip, rsp_valid && rsp_data.saturated, rsp_data.heat_index_tenths_f == 15'sd9999 || rsp_data.heat_index_tenths_f == -15'sd9999)
   `HIC_ASSERT_NOW(a_regress_floor, rsp_valid && rsp_data.formula_used != FORMULA_FALLBACK, rsp_data.heat_index_tenths_f >= 15'sd800)

endmodule

// ===== rtl/core/hic_ctrl.sv =====
module hic_ctrl import hic_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output stage_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready  = en[0];
   assign rsp_valid  = valid_ff[NUM_STAGES-1];
   assign ctrl.en    = en;
   assign ctrl.valid = valid_ff;

endmodule

// ===== rtl/core/hic_regress.sv =====
module hic_regress import hic_pkg::*; (
   input  logic                 clock,
   input  stage_ctrl_type       ctrl,
   input  hic_req_type          req_data,
   output logic signed [QW-1:0] q_base
);

   logic signed [11:0]   t1_ff, t1_in;
   logic [9:0]           h1_ff, h1_in;
   logic [22:0]          tsq1_ff, tsq1_in;
   logic [19:0]          hsq1_ff, hsq1_in;
   logic signed [21:0]   th1_ff, th1_in;
   logic signed [23:0]   tsq_w;

   logic signed [RW-1:0] pt2_ff, pt2_in, ph2_ff, ph2_in, pth2_ff, pth2_in;
   logic signed [RW-1:0] ptsq2_ff, ptsq2_in, phsq2_ff, phsq2_in;
   logic [32:0]          tsqh2_ff, tsqh2_in;
   logic signed [31:0]   thsq2_ff, thsq2_in;
   logic [42:0]          tsqhsq2_ff, tsqhsq2_in;

   logic signed [RW-1:0] lin3_ff, lin3_in, m13_ff, m13_in, m23_ff, m23_in;
   logic signed [RW-1:0] m33_ff, m33_in;

   logic signed [RW-1:0] sum_w, nn_w;
   logic [NW-1:0]        nn4_ff, nn4_in;

   logic [65:0]          est_w;
   logic [31:0]          est5_ff, est5_in;
   logic [NW-1:0]        nn5_ff;

   logic [60:0]          qd_w;
   logic [NW-1:0]        qd6_ff, qd6_in, nn6_ff;
   logic [31:0]          est6_ff;

   logic [NW-1:0]        rem_w;
   logic                 corr_w;
   logic signed [QW-1:0] q7_ff, q7_in;

   always_comb begin
      t1_in   = req_data.temp_tenths_f;
      h1_in   = req_data.humidity_tenths;
      tsq_w   = 24'(req_data.temp_tenths_f) * 24'(req_data.temp_tenths_f);
      tsq1_in = tsq_w[22:0];
      hsq1_in = 20'(req_data.humidity_tenths) * 20'(req_data.humidity_tenths);
      th1_in  = 22'(req_data.temp_tenths_f) * $signed(22'(req_data.humidity_tenths));

      pt2_in     = RW'(t1_ff) * REG_C_T;
      ph2_in     = $signed(RW'(h1_ff)) * REG_C_H;
      pth2_in    = RW'(th1_ff) * REG_C_TH;
      ptsq2_in   = $signed(RW'(tsq1_ff)) * REG_C_TSQ;
      phsq2_in   = $signed(RW'(hsq1_ff)) * REG_C_HSQ;
      tsqh2_in   = 33'(tsq1_ff) * 33'(h1_ff);
      thsq2_in   = 32'(th1_ff) * $signed(32'(h1_ff));
      tsqhsq2_in = 43'(tsq1_ff) * 43'(hsq1_ff);

      lin3_in = REG_C0 + pt2_ff + ph2_ff - pth2_ff - ptsq2_ff - phsq2_ff;
      m13_in  = $signed(RW'(tsqh2_ff)) * REG_C_TSQH;
      m23_in  = RW'(thsq2_ff) * REG_C_THSQ;
      m33_in  = $signed(RW'(tsqhsq2_ff)) * REG_C_TSQHSQ;

      sum_w  = lin3_ff + m13_ff + m23_ff - m33_ff;
      nn_w   = (sum_w <<< 5) + REG_N_OFFSET;
      nn4_in = nn_w[NW-1:0];

      est_w   = 66'(nn4_ff[NW-1:28]) * 66'(DIV_RECIP);
      est5_in = est_w[65:34];

      qd_w   = 61'(est5_ff) * 61'(DIV_D);
      qd6_in = qd_w[NW-1:0];

      rem_w  = nn6_ff - qd6_ff;
      corr_w = rem_w >= NW'(DIV_D);
      q7_in  = $signed({1'b0, est6_ff}) + $signed({32'b0, corr_w}) - Q_BIAS;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         t1_ff   <= t1_in;
         h1_ff   <= h1_in;
         tsq1_ff <= tsq1_in;
         hsq1_ff <= hsq1_in;
         th1_ff  <= th1_in;
      end
      if (ctrl.en[1]) begin
         pt2_ff     <= pt2_in;
         ph2_ff     <= ph2_in;
         pth2_ff    <= pth2_in;
         ptsq2_ff   <= ptsq2_in;
         phsq2_ff   <= phsq2_in;
         tsqh2_ff   <= tsqh2_in;
         thsq2_ff   <= thsq2_in;
         tsqhsq2_ff <= tsqhsq2_in;
      end
      if (ctrl.en[2]) begin
         lin3_ff <= lin3_in;
         m13_ff  <= m13_in;
         m23_ff  <= m23_in;
         m33_ff  <= m33_in;
      end
      if (ctrl.en[3]) begin
         nn4_ff <= nn4_in;
      end
      if (ctrl.en[4]) begin
         est5_ff <= est5_in;
         nn5_ff  <= nn4_ff;
      end
      if (ctrl.en[5]) begin
         qd6_ff  <= qd6_in;
         est6_ff <= est5_ff;
         nn6_ff  <= nn5_ff;
      end
      if (ctrl.en[6]) begin
         q7_ff <= q7_in;
      end
   end

   assign q_base = q7_ff;

endmodule

// ===== rtl/core/hic_adjust.sv =====
module hic_adjust import hic_pkg::*; (
   input  logic           clock,
   input  stage_ctrl_type ctrl,
   input  hic_req_type    req_data,
   output adj_type        adj_out
);

   logic signed [11:0]   t_w;
   logic [9:0]           h_w;
   logic                 dry_w, hum_w;
   logic signed [12:0]   d_w;
   logic [7:0]           hd_w;
   logic [6:0]           td_w;
   logic signed [23:0]   fb_w;

   formula_type          f1_ff, f1_in, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff, f7_ff;
   logic [7:0]           a1_ff, a1_in, hm1_ff, hm1_in, hm2_ff;
   logic [14:0]          hp1_ff, hp1_in;
   logic [19:0]          fby1_ff, fby1_in;

   logic [16:0]          root2_ff, root2_in;
   logic [41:0]          hum2_ff, hum2_in;
   logic [40:0]          fbp2_ff, fbp2_in;

   logic [23:0]          dp3_ff, dp3_in;
   logic [17:0]          ha3_ff, ha3_in, ha4_ff, ha5_ff;
   logic signed [FW-1:0] fbt3_ff, fbt3_in, fbt4_ff, fbt5_ff, fbt6_ff, fbt7_ff;

   logic [41:0]          dr4_ff, dr4_in;
   logic [17:0]          da5_ff, da5_in;
   logic signed [AW-1:0] adj6_ff, adj6_in, adj7_ff;

   always_comb begin
      t_w   = req_data.temp_tenths_f;
      h_w   = req_data.humidity_tenths;
      dry_w = (h_w < 10'd130) && (t_w > 12'sd800) && (t_w < 12'sd1120);
      hum_w = (h_w > 10'd850) && (t_w > 12'sd800) && (t_w < 12'sd870);
      if (dry_w) begin
         f1_in = FORMULA_DRY;
      end else if (hum_w) begin
         f1_in = FORMULA_HUMID;
      end else begin
         f1_in = FORMULA_PLAIN;
      end
      d_w     = 13'(t_w) - 13'sd950;
      a1_in   = d_w[12] ? 8'(-d_w) : d_w[7:0];
      hm1_in  = 8'(10'd130 - h_w);
      hd_w    = 8'(h_w - 10'd850);
      td_w    = 7'(12'sd870 - t_w);
      hp1_in  = 15'(hd_w) * 15'(td_w);
      fb_w    = 24'(t_w) * 24'sd1100 + $signed(24'(h_w)) * 24'sd47 + 24'sd2397500;
      fby1_in = fb_w[22:3];

      root2_in = ROOT_LUT[a1_ff];
      hum2_in  = 42'(hp1_ff) * 42'(HUM_RECIP);
      fbp2_in  = 41'(fby1_ff) * 41'(FB_RECIP);

      dp3_in  = 24'(hm2_ff) * 24'(root2_ff);
      ha3_in  = hum2_ff[40:23];
      fbt3_in = $signed(FW'(fbp2_ff[39:27])) - 14'sd2500;

      dr4_in = 42'(dp3_ff[23:3]) * 42'(DRY_RECIP);
      da5_in = dr4_ff[40:23];

      case (f5_ff)
         FORMULA_DRY:   adj6_in = -$signed({1'b0, da5_ff});
         FORMULA_HUMID: adj6_in = $signed({1'b0, ha5_ff});
         default:       adj6_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         f1_ff   <= f1_in;
         a1_ff   <= a1_in;
         hm1_ff  <= hm1_in;
         hp1_ff  <= hp1_in;
         fby1_ff <= fby1_in;
      end
      if (ctrl.en[1]) begin
         f2_ff    <= f1_ff;
         root2_ff <= root2_in;
         hm2_ff   <= hm1_ff;
         hum2_ff  <= hum2_in;
         fbp2_ff  <= fbp2_in;
      end
      if (ctrl.en[2]) begin
         f3_ff   <= f2_ff;
         dp3_ff  <= dp3_in;
         ha3_ff  <= ha3_in;
         fbt3_ff <= fbt3_in;
      end
      if (ctrl.en[3]) begin
         f4_ff   <= f3_ff;
         dr4_ff  <= dr4_in;
         ha4_ff  <= ha3_ff;
         fbt4_ff <= fbt3_ff;
      end
      if (ctrl.en[4]) begin
         f5_ff   <= f4_ff;
         da5_ff  <= da5_in;
         ha5_ff  <= ha4_ff;
         fbt5_ff <= fbt4_ff;
      end
      if (ctrl.en[5]) begin
         f6_ff   <= f5_ff;
         adj6_ff <= adj6_in;
         fbt6_ff <= fbt5_ff;
      end
      if (ctrl.en[6]) begin
         f7_ff   <= f6_ff;
         adj7_ff <= adj6_ff;
         fbt7_ff <= fbt6_ff;
      end
   end

   assign adj_out.formula   = f7_ff;
   assign adj_out.adj       = adj7_ff;
   assign adj_out.fb_tenths = fbt7_ff;

endmodule

// ===== sim/testbench.sv =====
module testbench;
   import hic_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hic_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hic_rsp_type rsp_data;

   localparam int LATENCY = 9;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_RANDOM = 800;

   heat_index_calculator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic hic_rsp_type heat_index(hic_req_type rq);
      hic_rsp_type rs;
      longint t;
      longint h;
      longint r;
      longint q;
      longint a;
      longint s;
      longint tenths;
      longint unsigned arg;
      formula_type f;
      t = longint'(rq.temp_tenths_f);
      h = longint'({1'b0, rq.humidity_tenths});
      f = FORMULA_PLAIN;
      r = -64'sd42379000000000;
      r = r + 204901523 * t * 1000;
      r = r + 1014333127 * h * 1000;
      r = r - 22475541 * t * h * 100;
      r = r - 683783 * t * t * 100;
      r = r - 5481717 * h * h * 100;
      r = r + 122874 * t * t * h * 10;
      r = r + 85282 * t * h * h * 10;
      r = r - 199 * t * t * h * h;
      q = floor_quot(r * 32 + 244140625, 488281250);
      if (h < 130 && t > 800 && t < 1120) begin
         a = (t < 950) ? 950 - t : t - 950;
         arg = (longint'(170 - a) << 32) / 170;
         s = int_root(arg);
         q = q - floor_quot((130 - h) * s, 40);
         f = FORMULA_DRY;
      end else if (h > 850 && t > 800 && t < 870) begin
         q = q + floor_quot((h - 850) * (870 - t) * 65536, 5000);
         f = FORMULA_HUMID;
      end
      if (q < 80 * 65536) begin
         tenths = floor_quot(1100 * t + 47 * h - 103000 + 500, 1000);
         f = FORMULA_FALLBACK;
      end else begin
         tenths = floor_quot(q * 10 + 32768, 65536);
      end
      rs.saturated = 1'b0;
      if (tenths > 9999) begin
         tenths = 9999;
         rs.saturated = 1'b1;
      end else if (tenths < -9999) begin
         tenths = -9999;
         rs.saturated = 1'b1;
      end
      rs.heat_index_tenths_f = tenths[14:0];
      rs.formula_used = f;
      return rs;
   endfunction

   class heat_index_board;
      hic_rsp_type pending[$];
      int errors;

      function void note_reading(hic_req_type rq);
         pending.push_back(heat_index(rq));
      endfunction

      function void check_index(hic_rsp_type got);
         hic_rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected transaction %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.heat_index_tenths_f !== want.heat_index_tenths_f) begin
            $error("heat_index_tenths_f expected %0d actual %0d",
                   want.heat_index_tenths_f, got.heat_index_tenths_f);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
            errors++;
         end
         if (got.formula_used !== want.formula_used) begin
            $error("formula_used expected %0d actual %0d",
                   want.formula_used, got.formula_used);
            errors++;
         end
      endfunction
   endclass

   heat_index_board board = new();
   bit calm = 1'b0;
   bit stim_done = 1'b0;
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_reading(req_data);
         if (rsp_valid && rsp_ready) board.check_index(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // randomly stall the result side in bursts
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         rsp_ready <= 1'b1;
         if (calm || $urandom_range(0, 3) != 0) begin
            @(negedge clock);
         end else begin
            n = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send_reading(logic signed [11:0] t, logic [9:0] h);
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 19);
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.temp_tenths_f <= t;
      req_data.humidity_tenths <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      int sel;
      logic signed [11:0] t;
      logic [9:0] h;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_reading(12'sh800, 10'd0);
      send_reading(12'sh7ff, 10'h3ff);
      send_reading(-12'sd400, 10'd1000);
      send_reading(12'sd1760, 10'd1000);
      send_reading(12'sd0, 10'd0);
      send_reading(12'sd950, 10'd50);
      send_reading(12'sd801, 10'd129);
      send_reading(12'sd1119, 10'd0);
      send_reading(12'sd1120, 10'd100);
      send_reading(12'sd800, 10'd100);
      send_reading(12'sd850, 10'd900);
      send_reading(12'sd801, 10'd1000);
      send_reading(12'sd869, 10'd851);
      send_reading(12'sd870, 10'd900);
      send_reading(12'sd900, 10'd500);
      send_reading(12'sd1000, 10'd800);
      send_reading(12'sd700, 10'd400);
      send_reading(12'sd1300, 10'd600);
      drain_all();
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM * 3 / 4) calm = 1'b1;
         if (i == NUM_RANDOM / 2) drain_all();
         sel = $urandom_range(0, 9);
         case (sel)
            0, 1: begin
               t = 12'($urandom);
               h = 10'($urandom);
            end
            2, 3: begin
               t = 12'($urandom_range(801, 1119));
               h = 10'($urandom_range(0, 129));
            end
            4, 5: begin
               t = 12'($urandom_range(801, 869));
               h = 10'($urandom_range(851, 1023));
            end
            default: begin
               t = $signed(12'($urandom_range(0, 2160))) - 12'sd400;
               h = 10'($urandom_range(0, 1000));
            end
         endcase
         send_reading(t, h);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
